/* rtl/vsws_pkg.sv */
// Shared types and constants for the VAD sliding-window smoother.
package vsws_pkg;

	localparam int DEF_MAX_WINDOW = 64;
	localparam int CFG_W          = 7;

	localparam logic             RST_SMOOTHING_ENABLE = 1'b1;
	localparam logic [CFG_W-1:0] RST_WINDOW_LENGTH    = 7'd30;
	localparam logic [CFG_W-1:0] RST_START_LIMIT      = 7'd15;
	localparam logic [CFG_W-1:0] RST_END_LIMIT        = 7'd27;

	typedef enum logic [1:0] {
		REG_SMOOTHING_ENABLE = 2'd0,
		REG_WINDOW_LENGTH    = 2'd1,
		REG_START_LIMIT      = 2'd2,
		REG_END_LIMIT        = 2'd3
	} cfg_reg_t;

	// Row control broadcast to every window cell.
	typedef struct packed {
		logic push;
		logic pop;
		logic din;
	} win_ctrl_t;

endpackage

/* rtl/vsws_in_if.sv */
// Input channel: one frame decision or a flush command.
interface vsws_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic raw_speech;

	modport source (output valid, output mode, output raw_speech, input ready);
	modport sink (input valid, input mode, input raw_speech, output ready);
endinterface

/* rtl/vsws_out_if.sv */
// Output channel: one smoothed decision per frame.
interface vsws_out_if;
	logic valid;
	logic ready;
	logic speech_out;
	logic last;

	modport source (output valid, output speech_out, output last, input ready);
	modport sink (input valid, input speech_out, input last, output ready);
endinterface

/* rtl/vsws_cell.sv */
// One window cell: holds one frame bit, shifts toward the head on pop.
module vsws_cell #(
	parameter int MAX_WINDOW = vsws_pkg::DEF_MAX_WINDOW,
	parameter int IDX        = 0,
	localparam int IW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                clk,
	input  vsws_pkg::win_ctrl_t ctrl,
	input  logic [IW-1:0]       target,
	input  logic                next_bit,
	output logic                bit_q
);

	logic load;

	assign load = ctrl.push && (target == IW'(IDX));

	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= ctrl.din;
		end else if (ctrl.pop) begin
			bit_q <= next_bit;
		end
	end

endmodule

/* rtl/vsws_window.sv */
// Row of window cells; cell 0 always holds the oldest frame.
module vsws_window #(
	parameter int MAX_WINDOW = vsws_pkg::DEF_MAX_WINDOW,
	localparam int IW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                clk,
	input  vsws_pkg::win_ctrl_t ctrl,
	input  logic [IW-1:0]       target,
	output logic                oldest
);

	logic [MAX_WINDOW:0] chain;

	assign chain[MAX_WINDOW] = 1'b0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		vsws_cell #(
			.MAX_WINDOW (MAX_WINDOW),
			.IDX        (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.target   (target),
			.next_bit (chain[i+1]),
			.bit_q    (chain[i])
		);
	end

	assign oldest = chain[0];

endmodule

/* rtl/vad_sliding_window_smoother.sv */
// VAD sliding-window smoother: top level with control, counters and result register.
// Latency: the first result of an item is offered in the cycle after its transfer.
// Throughput: one item per cycle unless the output stalls; an item with n results
// holds the result register until all n are sent; the next is taken as the last goes.
// Reset: arst_n clears fill, count, active flag, result register and restores config
// defaults; window cells are not reset and are only read after being written.
module vad_sliding_window_smoother #(
	parameter int MAX_WINDOW = vsws_pkg::DEF_MAX_WINDOW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [vsws_pkg::CFG_W-1:0] cfg_wdata,
	vsws_in_if.sink                    frames,
	vsws_out_if.source                 decisions
);

	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = (FW > vsws_pkg::CFG_W) ? FW : vsws_pkg::CFG_W;

	logic                       smoothing_enable_q;
	logic [vsws_pkg::CFG_W-1:0] window_length_q;
	logic [vsws_pkg::CFG_W-1:0] start_limit_q;
	logic [vsws_pkg::CFG_W-1:0] end_limit_q;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] count_q;
	logic          active_q;

	logic          out_valid_q;
	logic          out_bit_q;
	logic [FW-1:0] out_rem_q;

	logic                in_acc;
	logic                out_acc;
	logic                oldest;
	logic [CW-1:0]       len_eff;
	logic [CW-1:0]       len_raw;
	logic                full;
	logic                fire;
	vsws_pkg::win_ctrl_t ctrl;
	logic [FW-1:0]       target;
	logic [FW-1:0]       n_res;
	logic                v_res;
	logic [FW-1:0]       fill_d;
	logic [FW-1:0]       count_d;
	logic                active_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_enable_q <= vsws_pkg::RST_SMOOTHING_ENABLE;
			window_length_q    <= vsws_pkg::RST_WINDOW_LENGTH;
			start_limit_q      <= vsws_pkg::RST_START_LIMIT;
			end_limit_q        <= vsws_pkg::RST_END_LIMIT;
		end else if (cfg_we) begin
			unique case (vsws_pkg::cfg_reg_t'(cfg_index))
				vsws_pkg::REG_SMOOTHING_ENABLE: smoothing_enable_q <= cfg_wdata[0];
				vsws_pkg::REG_WINDOW_LENGTH:    window_length_q    <= cfg_wdata;
				vsws_pkg::REG_START_LIMIT:      start_limit_q      <= cfg_wdata;
				vsws_pkg::REG_END_LIMIT:        end_limit_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_acc = decisions.valid && decisions.ready;
	assign frames.ready = !out_valid_q || (decisions.ready && out_rem_q == FW'(1));
	assign in_acc = frames.valid && frames.ready;

	assign len_raw = CW'(window_length_q);
	always_comb begin
		if (len_raw == '0) begin
			len_eff = CW'(1);
		end else if (len_raw > CW'(MAX_WINDOW)) begin
			len_eff = CW'(MAX_WINDOW);
		end else begin
			len_eff = len_raw;
		end
	end

	assign full = CW'(fill_q) >= len_eff;

	always_comb begin
		if (active_q) begin
			fire = (CW'(fill_q) - CW'(count_q)) > CW'(end_limit_q);
		end else begin
			fire = CW'(count_q) > CW'(start_limit_q);
		end
	end

	// item decode: result count/value, next state, window control
	always_comb begin
		n_res     = '0;
		v_res     = active_q;
		fill_d    = fill_q;
		count_d   = count_q;
		active_d  = active_q;
		ctrl.push = 1'b0;
		ctrl.pop  = 1'b0;
		ctrl.din  = frames.raw_speech;
		target    = fill_q;
		if (frames.mode) begin
			n_res    = fill_q;
			fill_d   = '0;
			count_d  = '0;
			active_d = 1'b0;
		end else if (!smoothing_enable_q) begin
			n_res = FW'(1);
			v_res = frames.raw_speech;
		end else begin
			ctrl.push = 1'b1;
			if (full && fire) begin
				n_res    = fill_q;
				v_res    = 1'b1;
				active_d = !active_q;
				target   = '0;
				fill_d   = FW'(1);
				count_d  = FW'(frames.raw_speech);
			end else if (full) begin
				// slide: drop the oldest, append at the tail
				n_res    = FW'(1);
				ctrl.pop = 1'b1;
				target   = fill_q - FW'(1);
				count_d  = count_q - FW'(oldest) + FW'(frames.raw_speech);
			end else begin
				fill_d  = fill_q + FW'(1);
				count_d = count_q + FW'(frames.raw_speech);
			end
		end
		if (!in_acc) begin
			ctrl.push = 1'b0;
			ctrl.pop  = 1'b0;
		end
	end

	vsws_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk    (clk),
		.ctrl   (ctrl),
		.target (target[IW-1:0]),
		.oldest (oldest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			count_q  <= '0;
			active_q <= 1'b0;
		end else if (in_acc) begin
			fill_q   <= fill_d;
			count_q  <= count_d;
			active_q <= active_d;
		end
	end

	// result register: one value repeated out_rem_q times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
			out_rem_q   <= '0;
		end else if (in_acc && n_res != '0) begin
			out_valid_q <= 1'b1;
			out_bit_q   <= v_res;
			out_rem_q   <= n_res;
		end else if (out_acc) begin
			out_rem_q <= out_rem_q - FW'(1);
			if (out_rem_q == FW'(1)) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign decisions.valid      = out_valid_q;
	assign decisions.speech_out = out_bit_q;
	assign decisions.last       = (out_rem_q == FW'(1));

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_rem_q != '0)
		else $error("result pending with zero remaining count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_WINDOW))
		else $error("window fill above capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fill_q)
		else $error("speech count above window fill");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && frames.mode) |=> (fill_q == '0 && !active_q))
		else $error("flush did not clear window state");

endmodule
